/* hw/rtl/tce_pkg.sv */
package tce_pkg;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int STORE_SIZE  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = 11;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;

    localparam logic [7:0]  ESC_BYTE   = 8'h01;
    localparam logic [7:0]  BS_BYTE    = 8'h08;
    localparam logic [7:0]  TAB_BYTE   = 8'h09;
    localparam logic [7:0]  LF_BYTE    = 8'h0A;
    localparam logic [7:0]  CR_BYTE    = 8'h0D;
    localparam logic [7:0]  BLANK_CHAR = 8'h20;
    localparam logic [7:0]  RESET_ATTR = 8'h07;
    localparam logic [15:0] RESET_CELL = 16'h0720;

    typedef enum logic [1:0] {
        KIND_PRINT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_WRAP    = 2'd0,
        CFG_COLUMNS = 2'd1,
        CFG_ROWS    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SC_RD,
        ST_SC_WR,
        ST_FILL,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        char_byte;
        logic [ADDR_W-1:0] cell_address;
    } req_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } ctl_t;

    typedef struct packed {
        logic             wrap;
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] rows;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_location;
        logic [15:0]       cell_data;
        logic [7:0]        text_color;
    } result_t;

endpackage

/* hw/rtl/text_console_char_engine.sv */
// Character-cell text console engine.
//
// Input channel: in_valid / in_stall carry one request (kind, char_byte,
// cell_address). kind 0 feeds a byte to the interpreter, kind 1 reads one
// screen cell, kind 2 clears the active area and homes the cursor.
// Output channel: out_valid / out_stall return exactly one result per
// request, in order: cursor column, row, linear location, read data (zero
// unless a read) and the current attribute.
// Configuration: cfg_valid / cfg_ready write wrap_mode (0), columns (1) or
// rows (2); cfg_ready is always high. Write only while the console is idle.
//
// Sequence: a request is popped from a two-entry queue, clamped and sized
// in ST_IDLE, executed in ST_EXEC and its result registered from ST_DONE;
// reads and non-scrolling bytes and control codes go straight to ST_DONE.
// A scroll walks the store, reading each moved cell in ST_SC_RD and writing
// it one row up in ST_SC_WR, then fills the last row in ST_FILL. A clear
// fills the active area in ST_FILL. The queue absorbs two requests meanwhile.
// Reset: the 2000 store cells are filled with blank cells (0x0720);
// in_stall is held high until that pass ends. While out_stall is high and
// a result is held in the output register, the engine waits in ST_DONE.
module text_console_char_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    char_byte,
    input  logic [tce_pkg::ADDR_W-1:0]    cell_address,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [6:0]                    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tce_pkg::COL_W-1:0]     cursor_col,
    output logic [tce_pkg::ROW_W-1:0]     cursor_row,
    output logic [tce_pkg::ADDR_W-1:0]    cursor_location,
    output logic [15:0]                   cell_data,
    output logic [7:0]                    text_color
);
    import tce_pkg::*;

    logic             wrap_reg;
    logic [COL_W-1:0] cols_reg;
    logic [ROW_W-1:0] rows_reg;
    cfg_t             cfg;

    req_t    in_req;
    req_t    head;
    logic    head_valid;
    ctl_t    ctl;
    logic    out_free;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign cfg_ready = 1'b1;

    // saturate sizes into 1..max
    always_comb
    begin
        cfg.wrap = wrap_reg;
        if (cols_reg == '0)
        begin
            cfg.cols = 7'd1;
        end
        else if (cols_reg > COL_W'(MAX_COLUMNS))
        begin
            cfg.cols = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cfg.cols = cols_reg;
        end
        if (rows_reg == '0)
        begin
            cfg.rows = 5'd1;
        end
        else if (rows_reg > ROW_W'(MAX_ROWS))
        begin
            cfg.rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            cfg.rows = rows_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= 1'b0;
            cols_reg <= COL_W'(MAX_COLUMNS);
            rows_reg <= ROW_W'(MAX_ROWS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WRAP:    wrap_reg <= cfg_data[0];
                CFG_COLUMNS: cols_reg <= cfg_data;
                CFG_ROWS:    rows_reg <= cfg_data[ROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_req.kind         = kind;
    assign in_req.char_byte    = char_byte;
    assign in_req.cell_address = cell_address;

    tce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_req     (in_req),
        .ctl        (ctl),
        .head_valid (head_valid),
        .head       (head)
    );

    // the output slot frees when empty or being taken this edge
    assign out_free = !out_valid_reg || !out_stall;

    tce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .ctl        (ctl),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_col      = out_reg.cursor_col;
    assign cursor_row      = out_reg.cursor_row;
    assign cursor_location = out_reg.cursor_location;
    assign cell_data       = out_reg.cell_data;
    assign text_color      = out_reg.text_color;

endmodule

/* hw/rtl/tce_front.sv */
module tce_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tce_pkg::req_t in_req,
    input  tce_pkg::ctl_t ctl,
    output logic          head_valid,
    output tce_pkg::req_t head
);
    import tce_pkg::*;

    req_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_stall   = (count_reg == 2'd2) || ctl.init_busy;
    assign push       = in_valid && !in_stall;
    assign pop        = ctl.pop && (count_reg != 2'd0);
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/tce_back.sv */
module tce_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tce_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  tce_pkg::req_t    head,
    output tce_pkg::ctl_t    ctl,
    input  logic             out_free,
    output logic             res_valid,
    output tce_pkg::result_t res
);
    import tce_pkg::*;

    logic [15:0] mem [STORE_SIZE];

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] area_reg, area_next;
    logic [ADDR_W-1:0] move_end_reg, move_end_next;
    logic [15:0]       fill_data_reg, fill_data_next;
    logic [COL_W-1:0]  cx_reg, cx_next;
    logic [ROW_W-1:0]  cy_reg, cy_next;
    logic [7:0]        attr_reg, attr_next;
    logic              esc_reg, esc_next;
    req_t              req_reg, req_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [15:0]       mem_rdata_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // print interpreter
    logic [COL_W-1:0]  ex_x;
    logic [ROW_W:0]    ex_y;
    logic              ex_wr;
    logic [COL_W-1:0]  ex_wx;
    logic [ROW_W-1:0]  ex_wy;
    logic [7:0]        ex_ch;
    logic              ex_chk;
    logic              ex_ovf;
    logic              ex_scroll;
    logic [7:0]        tab_x;
    logic [7:0]        inc_x;
    logic [11:0]       ex_addr;
    logic [11:0]       loc;
    logic [11:0]       area_full;

    always_comb
    begin
        ex_x      = cx_reg;
        ex_y      = {1'b0, cy_reg};
        ex_wr     = 1'b0;
        ex_wx     = cx_reg;
        ex_wy     = cy_reg;
        ex_ch     = req_reg.char_byte;
        ex_chk    = 1'b0;
        attr_next = attr_reg;
        esc_next  = esc_reg;
        tab_x     = ({1'b0, cx_reg} + 8'd4) & 8'hFC;
        inc_x     = {1'b0, cx_reg} + 8'd1;
        if (state_reg == ST_EXEC && req_reg.kind == KIND_PRINT)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                if (req_reg.char_byte != 8'd0)
                begin
                    attr_next = {attr_reg[7:4], req_reg.char_byte[3:0]};
                end
            end
            else
            begin
                case (req_reg.char_byte)
                    ESC_BYTE:
                    begin
                        esc_next = 1'b1;
                    end
                    BS_BYTE:
                    begin
                        if (cx_reg == '0)
                        begin
                            ex_x = cfg.cols - 7'd1;
                            if (cy_reg != '0)
                            begin
                                ex_y = {1'b0, cy_reg - 5'd1};
                            end
                        end
                        else
                        begin
                            ex_x = cx_reg - 7'd1;
                        end
                        ex_wr = 1'b1;
                        ex_wx = ex_x;
                        ex_wy = ex_y[ROW_W-1:0];
                        ex_ch = 8'd0;
                    end
                    CR_BYTE:
                    begin
                        ex_x = '0;
                    end
                    LF_BYTE:
                    begin
                        ex_x   = '0;
                        ex_y   = {1'b0, cy_reg} + 6'd1;
                        ex_chk = 1'b1;
                    end
                    TAB_BYTE:
                    begin
                        if (tab_x >= {1'b0, cfg.cols})
                        begin
                            ex_x = '0;
                            ex_y = {1'b0, cy_reg} + 6'd1;
                        end
                        else
                        begin
                            ex_x = tab_x[COL_W-1:0];
                        end
                        ex_chk = 1'b1;
                    end
                    default:
                    begin
                        ex_wr = 1'b1;
                        if (inc_x >= {1'b0, cfg.cols})
                        begin
                            ex_x = '0;
                            ex_y = {1'b0, cy_reg} + 6'd1;
                        end
                        else
                        begin
                            ex_x = inc_x[COL_W-1:0];
                        end
                        ex_chk = 1'b1;
                    end
                endcase
            end
        end
        ex_ovf    = ex_chk && (ex_y >= {1'b0, cfg.rows});
        ex_scroll = ex_ovf && !cfg.wrap;
        if (ex_ovf)
        begin
            if (cfg.wrap)
            begin
                ex_x = '0;
                ex_y = '0;
            end
            else
            begin
                ex_y = {1'b0, cfg.rows - 5'd1};
            end
        end
        ex_addr   = ex_wy * cfg.cols + {5'd0, ex_wx};
        loc       = cy_reg * cfg.cols + {5'd0, cx_reg};
        area_full = cfg.rows * cfg.cols;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (ptr_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (req_reg.kind == KIND_CLEAR)
                begin
                    state_next = ST_FILL;
                end
                else if (ex_scroll)
                begin
                    state_next = (move_end_reg == '0) ? ST_FILL : ST_SC_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                state_next = (ptr_reg + 11'd1 == move_end_reg) ? ST_FILL : ST_SC_RD;
            end
            ST_FILL:
            begin
                if (ptr_reg + 11'd1 == area_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        ptr_next       = ptr_reg;
        area_next      = area_reg;
        move_end_next  = move_end_reg;
        fill_data_next = fill_data_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        req_next       = req_reg;
        rd_ok_next     = rd_ok_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = fill_data_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg + {4'd0, cfg.cols};
        ctl.pop        = 1'b0;
        ctl.init_busy  = 1'b0;
        res_valid      = 1'b0;
        res.cursor_col      = cx_reg;
        res.cursor_row      = cy_reg;
        res.cursor_location = loc[ADDR_W-1:0];
        res.cell_data       = (req_reg.kind == KIND_READ && rd_ok_reg) ? mem_rdata_reg : 16'd0;
        res.text_color      = attr_reg;
        case (state_reg)
            ST_INIT:
            begin
                ctl.init_busy = 1'b1;
                wr_en         = 1'b1;
                wr_data       = RESET_CELL;
                ptr_next      = (ptr_reg == ADDR_W'(STORE_SIZE - 1)) ? '0 : ptr_reg + 11'd1;
            end
            ST_IDLE:
            begin
                ctl.pop = head_valid;
                if (head_valid)
                begin
                    // clamp the cursor to the active area, hold sizes for the walks
                    req_next      = head;
                    cx_next       = (cx_reg >= cfg.cols) ? cfg.cols - 7'd1 : cx_reg;
                    cy_next       = (cy_reg >= cfg.rows) ? cfg.rows - 5'd1 : cy_reg;
                    area_next     = area_full[ADDR_W-1:0];
                    move_end_next = area_full[ADDR_W-1:0] - {4'd0, cfg.cols};
                    rd_ok_next    = (head.cell_address < ADDR_W'(STORE_SIZE));
                end
            end
            ST_EXEC:
            begin
                ptr_next = '0;
                cx_next  = ex_x;
                cy_next  = ex_y[ROW_W-1:0];
                if (req_reg.kind == KIND_READ)
                begin
                    rd_en   = rd_ok_reg;
                    rd_addr = req_reg.cell_address;
                end
                else if (req_reg.kind == KIND_CLEAR)
                begin
                    cx_next        = '0;
                    cy_next        = '0;
                    fill_data_next = {attr_reg, BLANK_CHAR};
                end
                else if (req_reg.kind == KIND_PRINT)
                begin
                    wr_en          = ex_wr;
                    wr_addr        = ex_addr[ADDR_W-1:0];
                    wr_data        = {attr_reg, ex_ch};
                    fill_data_next = {attr_reg, 8'd0};
                    if (ex_scroll && move_end_reg == '0)
                    begin
                        ptr_next = move_end_reg;
                    end
                end
            end
            ST_SC_RD:
            begin
                rd_en = 1'b1;
            end
            ST_SC_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = mem_rdata_reg;
                ptr_next = ptr_reg + 11'd1;
            end
            ST_FILL:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 11'd1;
            end
            ST_DONE:
            begin
                res_valid = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg      <= area_next;
        move_end_reg  <= move_end_next;
        fill_data_reg <= fill_data_next;
        req_reg       <= req_next;
        rd_ok_reg     <= rd_ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ptr_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            attr_reg  <= RESET_ATTR;
            esc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            attr_reg  <= attr_next;
            esc_reg   <= esc_next;
        end
    end

    a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> !ctl.pop)
        else $error("request taken during clearing pass");
    a_cx_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> (cx_reg < cfg.cols))
        else $error("cursor column outside active area");
    a_cy_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (cy_reg < cfg.rows))
        else $error("cursor row outside active area");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (ptr_reg < area_reg))
        else $error("fill walk past active area");

endmodule
